[sv/bbn_pkg.sv]
// Shared types and constants for the bounding box normalizer.
package bbn_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int OUT_FRAC_BITS = 16;
    localparam int OUT_WIDTH     = OUT_FRAC_BITS + 2;
    localparam int EXT_W         = COORD_WIDTH + 2;
    localparam int N_W           = COORD_WIDTH + 3;
    localparam int REM_W         = COORD_WIDTH + 2;
    localparam int DEN_W         = COORD_WIDTH + 1;
    localparam int Q_W           = OUT_FRAC_BITS + 1;
    localparam int CNT_W         = $clog2(Q_W);

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic [Q_W-1:0] Q_ONE = {1'b1, {OUT_FRAC_BITS{1'b0}}};

    typedef enum logic [1:0] {
        OP_CLEAR     = 2'd0,
        OP_MEASURE   = 2'd1,
        OP_TRANSFORM = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXT,
        ST_START,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic measure;
        logic capture;
        logic prep;
        logic start;
        logic step;
    } lane_ctl_t;

endpackage

[sv/bbn_lane.sv]
// One axis lane: box bounds, offset from the center and a restoring divider.
module bbn_lane (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  bbn_pkg::lane_ctl_t                     ctl,
    input  logic signed [bbn_pkg::COORD_WIDTH-1:0] v,
    input  logic        [bbn_pkg::DEN_W-1:0]       den,
    output logic signed [bbn_pkg::EXT_W-1:0]       ext,
    output logic                                   clip,
    output logic signed [bbn_pkg::OUT_WIDTH-1:0]   q_out
);
    import bbn_pkg::*;

    logic signed [COORD_WIDTH-1:0] low_reg, low_next;
    logic signed [COORD_WIDTH-1:0] high_reg, high_next;
    logic signed [COORD_WIDTH-1:0] v_reg;
    logic        [REM_W-1:0]       rem_reg;
    logic        [Q_W-1:0]         quo_reg;
    logic                          neg_reg;
    logic                          clip_reg;
    logic signed [N_W-1:0]         n;
    logic signed [N_W-1:0]         n_abs;
    logic        [REM_W-1:0]       den_ext;
    logic        [REM_W-1:0]       diff;
    logic                          ge;
    logic        [Q_W-1:0]         q_mag;
    logic        [OUT_WIDTH-1:0]   q_pos;

    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        if (ctl.clear)
        begin
            low_next  = COORD_MAX;
            high_next = COORD_MIN;
        end
        else if (ctl.measure)
        begin
            if (v < low_reg)
            begin
                low_next = v;
            end
            if (v > high_reg)
            begin
                high_next = v;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= COORD_MAX;
            high_reg <= COORD_MIN;
        end
        else
        begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    assign ext     = EXT_W'(high_reg) - EXT_W'(low_reg);
    assign n       = (N_W'(v_reg) <<< 1) - N_W'(high_reg) - N_W'(low_reg);
    assign n_abs   = (n < 0) ? -n : n;
    assign den_ext = REM_W'(den);
    assign ge      = (rem_reg >= den_ext);
    assign diff    = ge ? (rem_reg - den_ext) : rem_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            v_reg <= v;
        end
        if (ctl.prep)
        begin
            neg_reg <= (n < 0);
            rem_reg <= n_abs[REM_W-1:0];
        end
        else if (ctl.step)
        begin
            rem_reg <= {diff[REM_W-2:0], 1'b0};
        end
        if (ctl.start)
        begin
            clip_reg <= (rem_reg > den_ext);
            quo_reg  <= '0;
        end
        else if (ctl.step)
        begin
            quo_reg <= {quo_reg[Q_W-2:0], ge};
        end
    end

    assign clip  = clip_reg;
    assign q_mag = clip_reg ? Q_ONE : quo_reg;
    assign q_pos = {1'b0, q_mag};
    assign q_out = neg_reg ? $signed(~q_pos + 1'b1) : $signed(q_pos);

endmodule

[sv/bbn_merge.sv]
// Merge stage: largest extent over the lanes, degenerate test and clip summary.
module bbn_merge (
    input  logic                             clk,
    input  logic                             load,
    input  logic                             any_seen,
    input  logic signed [bbn_pkg::EXT_W-1:0] ext_x,
    input  logic signed [bbn_pkg::EXT_W-1:0] ext_y,
    input  logic signed [bbn_pkg::EXT_W-1:0] ext_z,
    input  logic        [2:0]                lane_clip,
    output logic        [bbn_pkg::DEN_W-1:0] den,
    output logic                             degen,
    output logic                             clip_any
);
    import bbn_pkg::*;

    logic signed [EXT_W-1:0] max_xy;
    logic signed [EXT_W-1:0] max_all;
    logic [DEN_W-1:0]        den_reg;
    logic                    degen_reg;

    assign max_xy  = (ext_y > ext_x) ? ext_y : ext_x;
    assign max_all = (ext_z > max_xy) ? ext_z : max_xy;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            den_reg   <= max_all[DEN_W-1:0];
            degen_reg <= !any_seen || (max_all <= 0);
        end
    end

    assign den      = den_reg;
    assign degen    = degen_reg;
    assign clip_any = |lane_clip;

endmodule

[sv/bounding_box_normalizer.sv]
// Top level of the bounding box normalizer: control, lanes, merge and result register.
//
//   Channel  Signals                                   Direction
//   in       in_valid, in_ready, operation, x/y/z_in   request into the block
//   out      out_valid, out_ready, x/y/z_out,          result out of the block
//            degenerate, clipped
//
// in_ready stays high after clear and measure requests.
// A transform request runs through ST_EXT, which finds the extents, ST_START, which
// starts the three lane dividers, 17 divider steps in ST_DIV, and ST_DONE, which waits
// for a free result register and loads it. Each lane has a 17-step radix-2 restoring
// divider. An empty or flat box skips the dividers, going from ST_START to ST_DONE.
// Reset empties the box; the result register keeps a result until out_ready takes it.
module bounding_box_normalizer (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic        [1:0]                        operation,
    input  logic signed [bbn_pkg::COORD_WIDTH-1:0]   x_in,
    input  logic signed [bbn_pkg::COORD_WIDTH-1:0]   y_in,
    input  logic signed [bbn_pkg::COORD_WIDTH-1:0]   z_in,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [bbn_pkg::OUT_WIDTH-1:0]     x_out,
    output logic signed [bbn_pkg::OUT_WIDTH-1:0]     y_out,
    output logic signed [bbn_pkg::OUT_WIDTH-1:0]     z_out,
    output logic                                     degenerate,
    output logic                                     clipped
);
    import bbn_pkg::*;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    seen_reg, seen_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    load_out;
    logic                    accept;
    lane_ctl_t               ctl;
    logic                    merge_load;
    logic signed [EXT_W-1:0] ext_x, ext_y, ext_z;
    logic [2:0]              lane_clip;
    logic [DEN_W-1:0]        den;
    logic                    degen;
    logic                    clip_any;
    logic signed [OUT_WIDTH-1:0] qx, qy, qz;
    logic signed [OUT_WIDTH-1:0] x_reg, y_reg, z_reg;
    logic                    degen_out_reg, clip_out_reg;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        seen_next  = seen_reg;
        ctl        = '0;
        merge_load = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        OP_CLEAR:
                        begin
                            ctl.clear = 1'b1;
                            seen_next = 1'b0;
                        end
                        OP_MEASURE:
                        begin
                            ctl.measure = 1'b1;
                            seen_next   = 1'b1;
                        end
                        OP_TRANSFORM:
                        begin
                            ctl.capture = 1'b1;
                            state_next  = ST_EXT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EXT:
            begin
                ctl.prep   = 1'b1;
                merge_load = 1'b1;
                state_next = ST_START;
            end
            ST_START:
            begin
                cnt_next = '0;
                if (degen)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ctl.start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                ctl.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(Q_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    bbn_lane u_lane_x (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .v     (x_in),
        .den   (den),
        .ext   (ext_x),
        .clip  (lane_clip[0]),
        .q_out (qx)
    );

    bbn_lane u_lane_y (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .v     (y_in),
        .den   (den),
        .ext   (ext_y),
        .clip  (lane_clip[1]),
        .q_out (qy)
    );

    bbn_lane u_lane_z (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .v     (z_in),
        .den   (den),
        .ext   (ext_z),
        .clip  (lane_clip[2]),
        .q_out (qz)
    );

    bbn_merge u_merge (
        .clk       (clk),
        .load      (merge_load),
        .any_seen  (seen_reg),
        .ext_x     (ext_x),
        .ext_y     (ext_y),
        .ext_z     (ext_z),
        .lane_clip (lane_clip),
        .den       (den),
        .degen     (degen),
        .clip_any  (clip_any)
    );

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (degen)
            begin
                x_reg        <= '0;
                y_reg        <= '0;
                z_reg        <= '0;
                degen_out_reg <= 1'b1;
                clip_out_reg  <= 1'b0;
            end
            else
            begin
                x_reg        <= qx;
                y_reg        <= qy;
                z_reg        <= qz;
                degen_out_reg <= 1'b0;
                clip_out_reg  <= clip_any;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign x_out      = x_reg;
    assign y_out      = y_reg;
    assign z_out      = z_reg;
    assign degenerate = degen_out_reg;
    assign clipped    = clip_out_reg;

    a_transform_enters_ext: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (operation == OP_TRANSFORM) |=> (state_reg == ST_EXT))
        else $error("Transform request did not start the extent cycle.");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("Result appeared without a finished transform.");

    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && degen_out_reg |->
            (x_reg == 0) && (y_reg == 0) && (z_reg == 0) && !clip_out_reg)
        else $error("Degenerate result carries nonzero data.");

    a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            (x_reg <= $signed({2'b00, {OUT_FRAC_BITS{1'b0}}} | OUT_WIDTH'(Q_ONE)))
            && (x_reg >= -$signed(OUT_WIDTH'(Q_ONE))))
        else $error("Normalized x lies outside plus or minus one.");

    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg < CNT_W'(Q_W)))
        else $error("Divider step count overran.");

endmodule

[tb/tb.sv]
// Self-checking testbench for the bounding box normalizer, with directed and random requests.
`timescale 1ns / 100ps

module tb;
    import bbn_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [OUT_WIDTH-1:0] norm_t;

    typedef struct {
        norm_t x;
        norm_t y;
        norm_t z;
        logic  degenerate;
        logic  clipped;
    } norm_result_t;

    class norm_scoreboard;
        longint box_lo[3];
        longint box_hi[3];
        bit box_valid;
        norm_result_t pending[$];
        int unsigned fails;

        function new();
            empty_box();
            fails = 0;
        endfunction

        function void empty_box();
            for (int a = 0; a < 3; a++)
            begin
                box_lo[a] = COORD_MAX;
                box_hi[a] = COORD_MIN;
            end
            box_valid = 1'b0;
        endfunction

        function norm_t scale_axis(longint v, longint lo, longint hi, longint span,
                                   inout bit clip);
            longint n;
            longint unsigned mag;
            longint unsigned q;
            n = 2 * v - hi - lo;
            mag = (n < 0) ? -n : n;
            if (mag > span)
            begin
                clip = 1'b1;
                q = longint'(1) << OUT_FRAC_BITS;
            end
            else
            begin
                q = (mag << OUT_FRAC_BITS) / span;
            end
            if (n < 0)
            begin
                q = -q;
            end
            return q[OUT_WIDTH-1:0];
        endfunction

        function void note_request(logic [1:0] op, coord_t x, coord_t y, coord_t z);
            longint v[3];
            longint span;
            bit clip;
            norm_result_t r;
            v[0] = x;
            v[1] = y;
            v[2] = z;
            if (op == OP_CLEAR)
            begin
                empty_box();
            end
            else if (op == OP_MEASURE)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    if (v[a] < box_lo[a]) box_lo[a] = v[a];
                    if (v[a] > box_hi[a]) box_hi[a] = v[a];
                end
                box_valid = 1'b1;
            end
            else if (op == OP_TRANSFORM)
            begin
                span = 0;
                if (box_valid)
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        if (box_hi[a] - box_lo[a] > span) span = box_hi[a] - box_lo[a];
                    end
                end
                clip = 1'b0;
                if (span <= 0)
                begin
                    r.x = '0;
                    r.y = '0;
                    r.z = '0;
                    r.degenerate = 1'b1;
                end
                else
                begin
                    r.x = scale_axis(v[0], box_lo[0], box_hi[0], span, clip);
                    r.y = scale_axis(v[1], box_lo[1], box_hi[1], span, clip);
                    r.z = scale_axis(v[2], box_lo[2], box_hi[2], span, clip);
                    r.degenerate = 1'b0;
                end
                r.clipped = clip;
                pending.push_back(r);
            end
        endfunction

        function void check_result(norm_t x, norm_t y, norm_t z, logic deg, logic clip);
            norm_result_t e;
            if (pending.size() == 0)
            begin
                $error("result with no request waiting: x %0d y %0d z %0d", x, y, z);
                fails++;
                return;
            end
            e = pending.pop_front();
            if (x !== e.x)
            begin
                $error("x_out: expected %0d, actual %0d", e.x, x);
                fails++;
            end
            if (y !== e.y)
            begin
                $error("y_out: expected %0d, actual %0d", e.y, y);
                fails++;
            end
            if (z !== e.z)
            begin
                $error("z_out: expected %0d, actual %0d", e.z, z);
                fails++;
            end
            if (deg !== e.degenerate)
            begin
                $error("degenerate: expected %0d, actual %0d", e.degenerate, deg);
                fails++;
            end
            if (clip !== e.clipped)
            begin
                $error("clipped: expected %0d, actual %0d", e.clipped, clip);
                fails++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] operation;
    coord_t x_in;
    coord_t y_in;
    coord_t z_in;
    logic out_valid;
    logic out_ready;
    norm_t x_out;
    norm_t y_out;
    norm_t z_out;
    logic degenerate;
    logic clipped;

    norm_scoreboard sb = new();
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int unsigned cycles = 0;

    bounding_box_normalizer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .x_in       (x_in),
        .y_in       (y_in),
        .z_in       (z_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .x_out      (x_out),
        .y_out      (y_out),
        .z_out      (z_out),
        .degenerate (degenerate),
        .clipped    (clipped)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(x_out, y_out, z_out, degenerate, clipped);
        end
    end

    task automatic offer_request(input logic [1:0] op, input coord_t x, input coord_t y,
                                 input coord_t z);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        operation <= op;
        x_in <= x;
        y_in <= y;
        z_in <= z;
        do @(posedge clk); while (!in_ready);
        sb.note_request(op, x, y, z);
    endtask

    function automatic coord_t pick_between(longint lo, longint hi);
        longint unsigned span;
        longint unsigned r;
        span = longint'(hi - lo) + 1;
        r = {$urandom, $urandom};
        return coord_t'(lo + longint'(r % span));
    endfunction

    task automatic run_random(input int target);
        int sent;
        int shift;
        longint lo[3];
        longint hi[3];
        longint c;
        longint w;
        logic [1:0] op;
        coord_t p[3];
        int pick;
        sent = 0;
        while (sent < target)
        begin
            if ($urandom_range(99) < 8)
            begin
                op = 2'($urandom_range(3));
                offer_request(op, $urandom, $urandom, $urandom);
                if (op != OP_UNUSED) sent++;
            end
            else
            begin
                if ($urandom_range(99) < 80)
                begin
                    offer_request(OP_CLEAR, $urandom, $urandom, $urandom);
                    sent++;
                end
                shift = $urandom_range(31);
                for (int a = 0; a < 3; a++)
                begin
                    c = longint'($signed($urandom)) >>> shift;
                    w = ($urandom_range(9) == 0) ? 0 : longint'(1) << $urandom_range(31);
                    lo[a] = (c - w < COORD_MIN) ? COORD_MIN : c - w;
                    hi[a] = (c + w > COORD_MAX) ? COORD_MAX : c + w;
                end
                repeat ($urandom_range(1, 6))
                begin
                    for (int a = 0; a < 3; a++) p[a] = pick_between(lo[a], hi[a]);
                    if ($urandom_range(9) == 0)
                    begin
                        offer_request(OP_UNUSED, $urandom, $urandom, $urandom);
                    end
                    offer_request(OP_MEASURE, p[0], p[1], p[2]);
                    sent++;
                end
                repeat ($urandom_range(1, 10))
                begin
                    pick = $urandom_range(9);
                    for (int a = 0; a < 3; a++)
                    begin
                        if (pick == 0) p[a] = $urandom;
                        else if (pick == 1) p[a] = coord_t'($urandom_range(1) ? hi[a] : lo[a]);
                        else p[a] = pick_between(lo[a], hi[a]);
                    end
                    offer_request(OP_TRANSFORM, p[0], p[1], p[2]);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_CLEAR;
        x_in = '0;
        y_in = '0;
        z_in = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty box, ignored code, flat box.
        offer_request(OP_TRANSFORM, COORD_MAX, COORD_MIN, 0);
        offer_request(OP_UNUSED, COORD_MAX, COORD_MAX, COORD_MAX);
        offer_request(OP_TRANSFORM, 1, 2, 3);
        offer_request(OP_MEASURE, 5 <<< 16, -(3 <<< 16), 7);
        offer_request(OP_TRANSFORM, 5 <<< 16, 0, -7);
        // Full coordinate range.
        offer_request(OP_CLEAR, 0, 0, 0);
        offer_request(OP_MEASURE, COORD_MIN, COORD_MIN, COORD_MIN);
        offer_request(OP_MEASURE, COORD_MAX, COORD_MAX, COORD_MAX);
        offer_request(OP_TRANSFORM, COORD_MAX, COORD_MIN, 0);
        offer_request(OP_TRANSFORM, 0, -1, 1);
        offer_request(OP_TRANSFORM, COORD_MIN, COORD_MAX, 32'h4000_0000);
        // Small box with saturation both ways and exact bounds.
        offer_request(OP_CLEAR, COORD_MAX, COORD_MIN, COORD_MAX);
        offer_request(OP_MEASURE, 0, 0, 0);
        offer_request(OP_UNUSED, COORD_MAX, COORD_MIN, COORD_MAX);
        offer_request(OP_MEASURE, 65536, 0, 0);
        offer_request(OP_TRANSFORM, 32768, 0, 0);
        offer_request(OP_TRANSFORM, 65536, 0, 0);
        offer_request(OP_TRANSFORM, COORD_MAX, COORD_MIN, 1);
        offer_request(OP_TRANSFORM, -65536, 65536, -1);
        offer_request(OP_MEASURE, 0, 3, -5);
        offer_request(OP_TRANSFORM, 1, 1, -1);
        offer_request(OP_CLEAR, 0, 0, 0);
        offer_request(OP_TRANSFORM, 0, 0, 0);

        snd_idle_pct = 7;
        rcv_idle_pct = 59;
        hold_req = 1'b1;
        run_random(570);
        snd_idle_pct = 59;
        rcv_idle_pct = 7;
        run_random(570);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_req = 1'b1;
        run_random(570);

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.fails == 0 && sb.pending.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/bbn_pkg.sv
sv/bbn_lane.sv
sv/bbn_merge.sv
sv/bounding_box_normalizer.sv
tb/tb.sv
